@@ rtl/kmsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsm_pkg
// Shared types and constants for the streaming pattern matcher.
// ----------------------------------------------------------------------------
package kmsm_pkg;

  localparam int BYTE_W         = 8;
  localparam int LENGTH_W       = 6;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_INDEX_W    = 3;
  localparam int PATTERN_WORDS  = 4;
  localparam int BYTES_PER_WORD = CFG_DATA_W / BYTE_W;
  localparam int PATTERN_BYTES  = PATTERN_WORDS * BYTES_PER_WORD;
  localparam int START_W        = 32;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4
  } cfg_reg_t;

  // Control handed to every cell of the chain
  typedef struct packed {
    logic advance;  // a text byte is transferred this cycle
    logic clear;    // drop all partial matches
  } cell_ctrl_t;

endpackage

@@ rtl/kmsm_text_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsm_text_if
// Text byte channel: valid/ready with byte and end-of-text mark.
// ----------------------------------------------------------------------------
interface kmsm_text_if
  import kmsm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ rtl/kmsm_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsm_result_if
// Result channel: valid/ready with match flag and match start offset.
// ----------------------------------------------------------------------------
interface kmsm_result_if
  import kmsm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               match_found;
  logic [START_W-1:0] match_start;

  modport source (output valid, output match_found, output match_start, input ready);
  modport sink   (input valid, input match_found, input match_start, output ready);
endinterface

@@ rtl/kmsm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsm_cell
// One comparator cell: holds "text suffix matches pattern prefix up to here".
// ----------------------------------------------------------------------------
module kmsm_cell
  import kmsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic [BYTE_W-1:0] pat_byte,
  input  logic              prev_hit,
  output logic              hit_next,
  output logic              hit
);

  assign hit_next = prev_hit && (text_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.clear) begin
      hit <= 1'b0;
    end else if (ctrl.advance) begin
      hit <= hit_next;
    end
  end

endmodule

@@ rtl/kmsm_pos_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsm_pos_counter
// Saturating text offset counter and match start offset.
// ----------------------------------------------------------------------------
module kmsm_pos_counter
  import kmsm_pkg::*;
#(
  parameter int POSITION_BITS = 32,
  parameter int LEN_W         = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic [LEN_W-1:0]   eff_len,
  output logic [START_W-1:0] start
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [POSITION_BITS-1:0] byte_count;
  logic [POSITION_BITS-1:0] diff;

  // Offset of the first byte of a match ending at the current byte
  assign diff  = byte_count + POSITION_BITS'(1) - POSITION_BITS'(eff_len);
  assign start = START_W'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (ctrl.clear) begin
      byte_count <= '0;
    end else if (ctrl.advance && (byte_count != POS_MAX)) begin
      byte_count <= byte_count + POSITION_BITS'(1);
    end
  end

endmodule

@@ rtl/kmp_stream_matcher_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_stream_matcher_core
// Streaming exact-pattern search with all overlapping matches reported.
// ----------------------------------------------------------------------------
//  channel    dir  payload                        transfer when
//  text_in    in   text_byte, end_of_text         valid && ready
//  result_out out  match_found, match_start       valid && ready
//  cfg        in   cfg_we, cfg_index, cfg_data    cfg_we high
//
//  One text byte per cycle while results are taken; its result is in the output
//  register on the next cycle. The rate is set by the comparator cell chain, where every
//  cell compares the byte against its pattern byte in the same cycle.
//  rst (synchronous) loads length 1 and an all-zero pattern and clears the
//  cells, the offset counter and the result valid flag.
//  A stalled result blocks the input only while it is not taken; a
//  transfer out frees the register for a transfer in on the same edge.
// ----------------------------------------------------------------------------
module kmp_stream_matcher_core
  import kmsm_pkg::*;
#(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  kmsm_text_if.sink              text_in,
  kmsm_result_if.source          result_out,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int CMP_W = LENGTH_W + 1;

  // Configuration registers
  logic [LENGTH_W-1:0]   pattern_length;
  logic [CFG_DATA_W-1:0] pattern_word [PATTERN_WORDS];
  logic                  cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LENGTH_W'(1);
      for (int w = 0; w < PATTERN_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: pattern_length  <= cfg_data[LENGTH_W-1:0];
        REG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
        REG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
        REG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
        REG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Only a known register restarts the search
  always_comb begin
    unique case (cfg_reg_t'(cfg_index))
      REG_PATTERN_LENGTH, REG_PATTERN_WORD_0, REG_PATTERN_WORD_1,
      REG_PATTERN_WORD_2, REG_PATTERN_WORD_3: cfg_hit = 1'b1;
      default:                                cfg_hit = 1'b0;
    endcase
  end

  // Length in use: zero acts as one, clamp at the chain length
  logic [CMP_W-1:0] len_wide;
  logic [LEN_W-1:0] eff_len;
  logic [IDX_W-1:0] last_cell;

  always_comb begin
    len_wide = CMP_W'(pattern_length);
    if (len_wide == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_wide > CMP_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(len_wide);
    end
  end

  assign last_cell = IDX_W'(eff_len - LEN_W'(1));

  // Handshake and output register
  logic       accept;
  cell_ctrl_t ctrl;
  cell_ctrl_t pos_ctrl;

  assign text_in.ready = !result_out.valid || result_out.ready;
  assign accept        = text_in.valid && text_in.ready;
  assign ctrl.advance  = accept;
  assign ctrl.clear    = (cfg_we && cfg_hit) || (accept && text_in.end_of_text);

  // Offset count runs on across a pattern rewrite; only end of text zeroes it
  assign pos_ctrl.advance = accept;
  assign pos_ctrl.clear   = accept && text_in.end_of_text;

  // Cell chain: cell k is set when the last k+1 bytes equal pattern[0..k]
  logic [BYTE_W-1:0] pat_bytes [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] hit_next;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic prev_hit;

    if (k < PATTERN_BYTES) begin : g_pat
      assign pat_bytes[k] =
        pattern_word[k / BYTES_PER_WORD][BYTE_W * (k % BYTES_PER_WORD) +: BYTE_W];
    end else begin : g_zero
      // bytes past the pattern registers read as zero
      assign pat_bytes[k] = '0;
    end

    if (k == 0) begin : g_head
      assign prev_hit = 1'b1;
    end else begin : g_link
      assign prev_hit = hit[k-1];
    end

    kmsm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .text_byte (text_in.text_byte),
      .pat_byte  (pat_bytes[k]),
      .prev_hit  (prev_hit),
      .hit_next  (hit_next[k]),
      .hit       (hit[k])
    );
  end

  logic               found;
  logic [START_W-1:0] start;

  assign found = hit_next[last_cell];

  kmsm_pos_counter #(
    .POSITION_BITS (POSITION_BITS),
    .LEN_W         (LEN_W)
  ) u_pos (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (pos_ctrl),
    .eff_len (eff_len),
    .start   (start)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (accept) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_out.match_found <= found;
      result_out.match_start <= found ? start : '0;
    end
  end

endmodule

@@ rtl/kmsm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsm_checker
// Port-level assertions for the matcher core, attached by bind.
// ----------------------------------------------------------------------------
module kmsm_checker
  import kmsm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               txt_valid,
  input logic               txt_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic               res_found,
  input logic [START_W-1:0] res_start
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_found |-> res_start == '0)
    else $error("match start nonzero without a match");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !txt_ready)
    else $error("input ready while result is stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    txt_valid && txt_ready |=> res_valid)
    else $error("no result after a text transfer");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_found) && $stable(res_start))
    else $error("stalled result changed");

endmodule

bind kmp_stream_matcher_core kmsm_checker u_kmsm_checker (
  .clk       (clk),
  .rst       (rst),
  .txt_valid (text_in.valid),
  .txt_ready (text_in.ready),
  .res_valid (result_out.valid),
  .res_ready (result_out.ready),
  .res_found (result_out.match_found),
  .res_start (result_out.match_start)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming pattern matcher. A KMP predictor with
// its own pattern registers, border table, partial-match length and text
// offset computes the expected flag and start offset for every byte
// transferred in. A checker compares each result transferred out against the
// oldest expected one. Directed tests cover the reset pattern, overlapping
// matches, end of text, out-of-range lengths, ignored register writes and a
// pattern rewrite inside a text. A long output stall fills the block.
// Random phases use random patterns from small alphabets with embedded full
// and partial copies.
// ----------------------------------------------------------------------------
module tb;
  import kmsm_pkg::*;

  localparam int MAX_PATTERN   = 32;
  localparam int POSITION_BITS = 32;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int HOLD_CYCLES   = 300;   // long output stall for the pressure test
  localparam int STALL_LIMIT   = 4000;  // cycles with no transfer before giving up
  localparam int TAIL_CYCLES   = 8;
  localparam int MAX_REPORTS   = 10;

  // a few printable bytes for the directed texts
  localparam logic [BYTE_W-1:0] CH_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_B = 8'h62;
  localparam logic [BYTE_W-1:0] CH_X = 8'h78;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
  } match_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  kmsm_text_if   text_ch ();
  kmsm_result_if result_ch ();

  kmp_stream_matcher_core #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(POSITION_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_ch),
    .result_out(result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the registers and the search state.
  // --------------------------------------------------------------------------
  logic [LENGTH_W-1:0]      pat_len_reg;
  logic [CFG_DATA_W-1:0]    pat_words [PATTERN_WORDS];
  int                       border_tbl [MAX_PATTERN+1];
  int                       partial_len;   // bytes of the pattern matched so far
  logic [POSITION_BITS-1:0] text_offset;   // offset of the next text byte

  match_result_t expected_matches [$];

  bit idle_enable  = 1'b1;  // random gaps on both sides
  bit hold_outputs = 1'b0;  // request for one long output stall
  int bytes_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int idle_cycles  = 0;

  // Length 0 behaves as 1, anything past the array size as the array size.
  function automatic int active_length();
    int n;
    n = int'(pat_len_reg);
    if (n < 1) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_byte(input int i);
    if (i < 0 || i >= PATTERN_BYTES) return '0;
    return pat_words[i / BYTES_PER_WORD][BYTE_W * (i % BYTES_PER_WORD) +: BYTE_W];
  endfunction

  // Classic KMP failure table, entry m holds the border used after a full
  // match so overlapping copies are found.
  function automatic void build_border_table();
    int m;
    int i;
    int j;
    m = active_length();
    i = 0;
    j = -1;
    border_tbl[0] = -1;
    while (i < m) begin
      while (j != -1 && pattern_byte(i) != pattern_byte(j)) j = border_tbl[j];
      i++;
      j++;
      if (i < m) begin
        border_tbl[i] = (pattern_byte(i) == pattern_byte(j)) ? border_tbl[j] : j;
      end else begin
        border_tbl[m] = j;
      end
    end
    partial_len = 0;
  endfunction

  function automatic void reset_predictor();
    pat_len_reg = LENGTH_W'(1);
    for (int k = 0; k < PATTERN_WORDS; k++) pat_words[k] = '0;
    text_offset = '0;
    build_border_table();
  endfunction

  // Register write as the block sees it; unknown indexes change nothing and
  // in particular keep the partial match.
  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_PATTERN_LENGTH) begin
      pat_len_reg = val[LENGTH_W-1:0];
    end else if (idx <= REG_PATTERN_WORD_3) begin
      pat_words[int'(idx) - int'(REG_PATTERN_WORD_0)] = val;
    end else begin
      return;
    end
    build_border_table();
  endfunction

  // One text byte in, one result out.
  function automatic match_result_t predict_match(input logic [BYTE_W-1:0] value,
                                                  input logic last);
    match_result_t r;
    int m;
    int j;
    m = active_length();
    j = partial_len;
    r = '0;
    if (j < 0 || j >= m) j = 0;
    while (j != -1 && pattern_byte(j) != value) j = border_tbl[j];
    j++;
    if (j == m) begin
      r.found     = 1'b1;
      r.start     = START_W'(text_offset + 1 - m);
      partial_len = border_tbl[m];
    end else begin
      partial_len = j;
    end
    // offset saturates instead of wrapping
    if (text_offset != '1) text_offset++;
    if (last) begin
      partial_len = 0;
      text_offset = '0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. Everything is driven with NBAs right after a rising edge and
  // sampled at the edge, so no ordering within a time step matters.
  // --------------------------------------------------------------------------

  // Leaves cfg_we high; the caller lowers it after its last write so that
  // back-to-back writes never assign cfg_we twice in one step.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_register(idx, val);
  endtask

  // Length value in the low bits, random junk above it.
  task automatic program_pattern(input logic [LENGTH_W-1:0] len_val,
                                 input logic [CFG_DATA_W-1:0] w0,
                                 input logic [CFG_DATA_W-1:0] w1,
                                 input logic [CFG_DATA_W-1:0] w2,
                                 input logic [CFG_DATA_W-1:0] w3);
    logic [CFG_DATA_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[LENGTH_W-1:0] = len_val;
    write_reg(REG_PATTERN_LENGTH, len_word);
    write_reg(REG_PATTERN_WORD_0, w0);
    write_reg(REG_PATTERN_WORD_1, w1);
    write_reg(REG_PATTERN_WORD_2, w2);
    write_reg(REG_PATTERN_WORD_3, w3);
    cfg_we <= 1'b0;
  endtask

  // Offer one byte, optionally after a random gap, and wait for its transfer.
  task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.text_byte   <= value;
    text_ch.end_of_text <= last;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    expected_matches.push_back(predict_match(value, last));
    bytes_sent++;
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic finish_text();
    text_ch.valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Reset pattern: one zero byte, so every zero byte matches at its own offset.
  task automatic test_reset_pattern();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    finish_text();
  endtask

  // "aba" overlaps itself; end of text inside a partial match drops it.
  task automatic test_overlap_and_end_of_text();
    program_pattern(LENGTH_W'(3), {{40{1'b1}}, 24'h616261}, '1, '0, '1);
    send_byte(CH_A, 1'b0);
    send_byte(CH_B, 1'b0);
    send_byte(CH_A, 1'b0);
    send_byte(CH_B, 1'b0);
    send_byte(CH_A, 1'b1);
    send_byte(CH_A, 1'b0);
    send_byte(CH_B, 1'b1);
    send_byte(CH_A, 1'b1);
    finish_text();
  endtask

  // Length 0 acts as 1; lengths past the top act as the full 32 bytes.
  task automatic test_length_limits();
    program_pattern(LENGTH_W'(0), 64'hff, '0, '0, '0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    finish_text();
    program_pattern(LENGTH_W'(63), '1, '1, '1, '1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    finish_text();
  endtask

  // Writes to unused indexes must not disturb the pattern or the partial match.
  task automatic test_unused_index();
    program_pattern(LENGTH_W'(2), {$urandom, 16'($urandom), CH_B, CH_A}, '0, '0, '0);
    send_byte(CH_A, 1'b0);
    finish_text();
    for (int k = int'(REG_PATTERN_WORD_3) + 1; k < (1 << CFG_INDEX_W); k++) begin
      write_reg(CFG_INDEX_W'(k), {$urandom, $urandom});
    end
    cfg_we <= 1'b0;
    send_byte(CH_B, 1'b1);
    finish_text();
  endtask

  // Rewriting the pattern inside a text drops the partial match but keeps
  // the offset count running.
  task automatic test_rewrite_inside_text();
    send_byte(CH_X, 1'b0);
    send_byte(CH_A, 1'b0);
    finish_text();
    write_reg(REG_PATTERN_WORD_0, pat_words[0]);
    cfg_we <= 1'b0;
    send_byte(CH_B, 1'b0);
    send_byte(CH_A, 1'b0);
    send_byte(CH_B, 1'b1);
    finish_text();
  endtask

  // Output held off for a long stretch while bytes keep coming: the result
  // register fills and the input must stall without losing anything.
  task automatic test_result_backpressure();
    bit saved_idle;
    saved_idle   = idle_enable;
    idle_enable  = 1'b0;
    program_pattern(LENGTH_W'(2), 64'h0000_0000_0000_6161, '0, '0, '0);
    hold_outputs = 1'b1;
    for (int k = 0; k < 60; k++) begin
      send_byte(($urandom_range(0, 3) != 0) ? CH_A : 8'($urandom_range(0, 255)), k == 59);
    end
    finish_text();
    idle_enable = saved_idle;
  endtask

  // --------------------------------------------------------------------------
  // Random phases
  // --------------------------------------------------------------------------

  // One pattern, then texts built from its alphabet with full and partial
  // copies mixed in, plus some full-range noise.
  task automatic run_random_phase(input int goal);
    logic [BYTE_W-1:0]     alphabet [4];
    logic [CFG_DATA_W-1:0] words [PATTERN_WORDS];
    logic [BYTE_W-1:0]     text_q [$];
    logic [LENGTH_W-1:0]   len_val;
    int n_sym;
    int sel;
    int m;
    int cut;
    int text_len;
    int first;
    bit close_text;
    n_sym = $urandom_range(1, 4);
    for (int k = 0; k < 4; k++) alphabet[k] = 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      len_val = LENGTH_W'(MAX_PATTERN);
    end else if (sel == 1) begin
      // out of range either way
      len_val = ($urandom_range(0, 1) != 0) ? LENGTH_W'(0) : LENGTH_W'($urandom_range(33, 63));
    end else if (sel == 2) begin
      len_val = LENGTH_W'($urandom_range(9, 31));
    end else begin
      len_val = LENGTH_W'($urandom_range(1, 8));
    end
    for (int b = 0; b < PATTERN_BYTES; b++) begin
      words[b / BYTES_PER_WORD][BYTE_W * (b % BYTES_PER_WORD) +: BYTE_W] =
        ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                    : alphabet[$urandom_range(0, n_sym - 1)];
    end
    program_pattern(len_val, words[0], words[1], words[2], words[3]);
    m     = active_length();
    first = bytes_sent;
    while (bytes_sent - first < goal) begin
      text_len = $urandom_range(1, 48);
      text_q.delete();
      while (text_q.size() < text_len) begin
        sel = $urandom_range(0, 15);
        if (sel < 2) cut = m;
        else if (sel == 2) cut = $urandom_range(1, m);
        else cut = 0;
        for (int k = 0; k < cut; k++) text_q.push_back(pattern_byte(k));
        if (cut == 0) begin
          text_q.push_back((sel < 5) ? 8'($urandom_range(0, 255))
                                     : alphabet[$urandom_range(0, n_sym - 1)]);
        end
      end
      // some texts run on into the next one without an end mark
      close_text = ($urandom_range(0, 3) != 0);
      foreach (text_q[k]) send_byte(text_q[k], close_text && (k == text_q.size() - 1));
    end
    finish_text();
  endtask

  task automatic test_random_texts();
    int base;
    base = bytes_sent;
    while (bytes_sent - base < RANDOM_ITEMS) begin
      // the last stretch runs with no gaps on either side
      idle_enable = (bytes_sent - base) < (RANDOM_ITEMS * 4) / 5;
      run_random_phase($urandom_range(60, 200));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready with random stall bursts, plus the one long hold.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_outputs) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_outputs = 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(input string what, input logic [START_W-1:0] want,
                               input logic [START_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s at result %0d: expected %0h, actual %0h",
               $realtime, what, results_seen, want, got);
    end
  endtask

  // Every result transfer is compared field by field with the oldest
  // expectation.
  always @(posedge clk) begin : check_results
    match_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_matches.size() == 0) begin
        note_mismatch("result with nothing pending", '0, result_ch.match_start);
      end else begin
        want = expected_matches.pop_front();
        if (result_ch.match_found !== want.found) begin
          note_mismatch("match_found", START_W'(want.found), START_W'(result_ch.match_found));
        end
        if (result_ch.match_start !== want.start) begin
          note_mismatch("match_start", want.start, result_ch.match_start);
        end
      end
      results_seen++;
    end
  end

  // Watchdog: too long without any transfer or register write means a hang.
  always @(posedge clk) begin
    if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    text_ch.valid       <= 1'b0;
    text_ch.text_byte   <= '0;
    text_ch.end_of_text <= 1'b0;
    reset_predictor();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_pattern();
    test_overlap_and_end_of_text();
    test_length_limits();
    test_unused_index();
    test_rewrite_inside_text();
    test_result_backpressure();
    test_random_texts();

    finish_text();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_matches.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
